@@ design/aomt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aomt_pkg
// Shared types and codes of the atomic modification order tracker.
// ----------------------------------------------------------------------------
package aomt_pkg;

  localparam int OBJECTS_DEF  = 64;
  localparam int VERSIONS_DEF = 1024;

  localparam int MODE_W    = 3;
  localparam int STATUS_W  = 3;
  localparam int SEL_W     = 16;
  localparam int READ_W    = 32;
  localparam int NEW_VER_W = 10;

  localparam logic [MODE_W-1:0] MODE_INIT  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_STORE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RMW   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CAS   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN_OBJ = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN_VER = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FOREIGN     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_STALE       = 3'd6;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd7;

  typedef struct packed {
    logic [31:0] root_id;
    logic [31:0] byte_offset;
    logic [7:0]  access_size;
  } obj_key_t;

  localparam int KEY_W = $bits(obj_key_t);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                version_valid;
    logic                read_valid;
    logic [READ_W-1:0]   read_id;
  } result_t;

endpackage

@@ design/atomic_modification_order_tracker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atomic_modification_order_tracker_unit
// Tracks the modification order of atomic objects keyed by root, offset and
// size, handing out version ids and read ids in order.
// ----------------------------------------------------------------------------
//  Channel | Handshake           | Payload
//  --------+---------------------+--------------------------------------------
//  in      | in_valid/in_ready   | mode root_id byte_offset access_size
//          |                     | version_sel cas_success
//  out     | out_valid/out_ready | status version_valid new_version read_valid
//          |                     | read_id
//
//  A transaction scans the object slots until the key matches (all filled
//  slots when it does not); the object table is read one slot per cycle.
//  Reset clears the counters; the tables need no clearing pass because
//  only filled slots and handed-out versions are ever read.
//  A finished result waits in the output register; a later transaction then
//  stalls in its final cycle until the register is free.
// ----------------------------------------------------------------------------
module atomic_modification_order_tracker_unit
  import aomt_pkg::*;
#(
  parameter int OBJECTS  = OBJECTS_DEF,
  parameter int VERSIONS = VERSIONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MODE_W-1:0]    mode,
  input  logic [31:0]          root_id,
  input  logic [31:0]          byte_offset,
  input  logic [7:0]           access_size,
  input  logic [SEL_W-1:0]     version_sel,
  input  logic                 cas_success,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  status,
  output logic                 version_valid,
  output logic [NEW_VER_W-1:0] new_version,
  output logic                 read_valid,
  output logic [READ_W-1:0]    read_id
);

  localparam int OW = (OBJECTS > 1) ? $clog2(OBJECTS) : 1;
  localparam int VW = $clog2(VERSIONS);

  logic          out_free, res_valid;
  result_t       res;
  logic [VW-1:0] res_version;

  logic          obj_rd_en, obj_wr_en;
  logic [OW-1:0] obj_rd_addr, obj_wr_addr;
  obj_key_t      obj_rd_key, obj_wr_key;
  logic [VW-1:0] obj_rd_tail, obj_wr_tail;

  logic          ver_rd_en, ver_wr_en;
  logic [VW-1:0] ver_rd_addr, ver_wr_addr;
  logic [OW-1:0] ver_rd_data, ver_wr_data;

  aomt_ctrl #(
    .OBJECTS  (OBJECTS),
    .VERSIONS (VERSIONS),
    .OW       (OW),
    .VW       (VW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .root_id     (root_id),
    .byte_offset (byte_offset),
    .access_size (access_size),
    .version_sel (version_sel),
    .cas_success (cas_success),
    .out_free    (out_free),
    .res_valid   (res_valid),
    .res         (res),
    .res_version (res_version),
    .obj_rd_en   (obj_rd_en),
    .obj_rd_addr (obj_rd_addr),
    .obj_rd_key  (obj_rd_key),
    .obj_rd_tail (obj_rd_tail),
    .obj_wr_en   (obj_wr_en),
    .obj_wr_addr (obj_wr_addr),
    .obj_wr_key  (obj_wr_key),
    .obj_wr_tail (obj_wr_tail),
    .ver_rd_en   (ver_rd_en),
    .ver_rd_addr (ver_rd_addr),
    .ver_rd_data (ver_rd_data),
    .ver_wr_en   (ver_wr_en),
    .ver_wr_addr (ver_wr_addr),
    .ver_wr_data (ver_wr_data)
  );

  aomt_obj_mem #(
    .DEPTH (OBJECTS),
    .AW    (OW),
    .TW    (VW)
  ) u_obj_mem (
    .clk     (clk),
    .rd_en   (obj_rd_en),
    .rd_addr (obj_rd_addr),
    .rd_key  (obj_rd_key),
    .rd_tail (obj_rd_tail),
    .wr_en   (obj_wr_en),
    .wr_addr (obj_wr_addr),
    .wr_key  (obj_wr_key),
    .wr_tail (obj_wr_tail)
  );

  aomt_ver_mem #(
    .DEPTH (VERSIONS),
    .AW    (VW),
    .DW    (OW)
  ) u_ver_mem (
    .clk     (clk),
    .rd_en   (ver_rd_en),
    .rd_addr (ver_rd_addr),
    .rd_data (ver_rd_data),
    .wr_en   (ver_wr_en),
    .wr_addr (ver_wr_addr),
    .wr_data (ver_wr_data)
  );

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      status        <= res.status;
      version_valid <= res.version_valid;
      new_version   <= NEW_VER_W'(res_version);
      read_valid    <= res.read_valid;
      read_id       <= res.read_id;
    end
  end

endmodule

@@ design/aomt_obj_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aomt_obj_mem
// Object table: key and tail version of each object, one read and one write
// port, registered read data.
// ----------------------------------------------------------------------------
module aomt_obj_mem
  import aomt_pkg::*;
#(
  parameter int DEPTH = OBJECTS_DEF,
  parameter int AW    = 6,
  parameter int TW    = 10
) (
  input  logic           clk,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output obj_key_t       rd_key,
  output logic [TW-1:0]  rd_tail,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  obj_key_t       wr_key,
  input  logic [TW-1:0]  wr_tail
);

  logic [KEY_W+TW-1:0] mem [DEPTH];
  logic [KEY_W+TW-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_key, wr_tail};
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  assign rd_key  = rd_word[KEY_W+TW-1:TW];
  assign rd_tail = rd_word[TW-1:0];

endmodule

@@ design/aomt_ver_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aomt_ver_mem
// Version owner table: the object slot that owns each version.
// ----------------------------------------------------------------------------
module aomt_ver_mem
  import aomt_pkg::*;
#(
  parameter int DEPTH = VERSIONS_DEF,
  parameter int AW    = 10,
  parameter int DW    = 6
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/aomt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aomt_ctrl
// Request sequencer: scans the object table for the key, checks the selected
// version against the owner table, and writes back the new version.
// ----------------------------------------------------------------------------
module aomt_ctrl
  import aomt_pkg::*;
#(
  parameter int OBJECTS  = OBJECTS_DEF,
  parameter int VERSIONS = VERSIONS_DEF,
  parameter int OW       = 6,
  parameter int VW       = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] mode,
  input  logic [31:0]       root_id,
  input  logic [31:0]       byte_offset,
  input  logic [7:0]        access_size,
  input  logic [SEL_W-1:0]  version_sel,
  input  logic              cas_success,
  input  logic              out_free,
  output logic              res_valid,
  output result_t           res,
  output logic [VW-1:0]     res_version,
  output logic              obj_rd_en,
  output logic [OW-1:0]     obj_rd_addr,
  input  obj_key_t          obj_rd_key,
  input  logic [VW-1:0]     obj_rd_tail,
  output logic              obj_wr_en,
  output logic [OW-1:0]     obj_wr_addr,
  output obj_key_t          obj_wr_key,
  output logic [VW-1:0]     obj_wr_tail,
  output logic              ver_rd_en,
  output logic [VW-1:0]     ver_rd_addr,
  input  logic [OW-1:0]     ver_rd_data,
  output logic              ver_wr_en,
  output logic [VW-1:0]     ver_wr_addr,
  output logic [OW-1:0]     ver_wr_data
);

  localparam int CNTW = $clog2(OBJECTS + 1);
  localparam int VCW  = $clog2(VERSIONS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state, state_next;

  logic [MODE_W-1:0] req_mode;
  obj_key_t          req_key;
  logic [SEL_W-1:0]  req_sel;
  logic              req_cas;

  logic [OW-1:0]     scan_idx;
  logic              found;
  logic [OW-1:0]     slot;
  logic [VW-1:0]     tail;

  logic [CNTW-1:0]   obj_count;
  logic [VCW-1:0]    vcount;
  logic [READ_W-1:0] rcount;

  logic accept, key_hit, scan_last, scan_stop, go;
  logic obj_full, vfull, rfull, sel_unknown;
  logic do_append, do_new_obj, do_read;
  logic [STATUS_W-1:0] status;
  logic [OW-1:0] target;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign key_hit   = (obj_rd_key == req_key);
  assign scan_last = ((CNTW'(scan_idx) + CNTW'(1)) == obj_count);
  assign scan_stop = key_hit || scan_last;
  assign go        = (state == S_EXEC) && out_free;

  assign obj_full    = (obj_count == CNTW'(OBJECTS));
  assign vfull       = (vcount == VCW'(VERSIONS));
  assign rfull       = (rcount == '1);
  assign sel_unknown = ({1'b0, req_sel} >= 17'(vcount));

  // Object table reads: slot 0 when a request arrives and the table is not empty, then one slot a cycle.
  always_comb begin
    obj_rd_en   = 1'b0;
    obj_rd_addr = '0;
    if (accept) begin
      obj_rd_en = (obj_count != '0);
    end else if (state == S_SCAN && !scan_stop) begin
      obj_rd_en   = 1'b1;
      obj_rd_addr = scan_idx + OW'(1);
    end
  end

  // The owner entry of the selected version is fetched at accept and held.
  assign ver_rd_en   = accept;
  assign ver_rd_addr = version_sel[VW-1:0];

  always_comb begin
    status     = ST_OK;
    do_append  = 1'b0;
    do_new_obj = 1'b0;
    do_read    = 1'b0;
    if (req_mode <= MODE_CAS) begin
      if (req_key.access_size == '0) begin
        status = ST_INVALID;
      end else if (req_mode == MODE_INIT) begin
        if (found) begin
          status = ST_DUPLICATE;
        end else if (obj_full || vfull) begin
          status = ST_FULL;
        end else begin
          do_new_obj = 1'b1;
          do_append  = 1'b1;
        end
      end else if (!found) begin
        status = ST_UNKNOWN_OBJ;
      end else if (req_mode == MODE_STORE) begin
        if (vfull) begin
          status = ST_FULL;
        end else begin
          do_append = 1'b1;
        end
      end else if (sel_unknown) begin
        status = ST_UNKNOWN_VER;
      end else if (ver_rd_data != slot) begin
        status = ST_FOREIGN;
      end else if (req_mode == MODE_LOAD || (req_mode == MODE_CAS && !req_cas)) begin
        if (rfull) begin
          status = ST_FULL;
        end else begin
          do_read = 1'b1;
        end
      end else if (req_sel != SEL_W'(tail)) begin
        status = ST_STALE;
      end else if (vfull || rfull) begin
        status = ST_FULL;
      end else begin
        do_read   = 1'b1;
        do_append = 1'b1;
      end
    end
  end

  assign target = do_new_obj ? obj_count[OW-1:0] : slot;

  assign obj_wr_en   = go && do_append;
  assign obj_wr_addr = target;
  assign obj_wr_key  = req_key;
  assign obj_wr_tail = vcount[VW-1:0];
  assign ver_wr_en   = go && do_append;
  assign ver_wr_addr = vcount[VW-1:0];
  assign ver_wr_data = target;

  assign res_valid         = go;
  assign res.status        = status;
  assign res.version_valid = do_append;
  assign res.read_valid    = do_read;
  assign res.read_id       = do_read ? rcount : '0;
  assign res_version       = do_append ? vcount[VW-1:0] : '0;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (obj_count == '0) ? S_EXEC : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_stop) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      obj_count <= '0;
      vcount    <= '0;
      rcount    <= '0;
    end else begin
      state <= state_next;
      if (go && do_append) begin
        vcount <= vcount + VCW'(1);
      end
      if (go && do_new_obj) begin
        obj_count <= obj_count + CNTW'(1);
      end
      if (go && do_read) begin
        rcount <= rcount + READ_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode             <= mode;
      req_key.root_id      <= root_id;
      req_key.byte_offset  <= byte_offset;
      req_key.access_size  <= access_size;
      req_sel              <= version_sel;
      req_cas              <= cas_success;
      scan_idx             <= '0;
      found                <= 1'b0;
    end else if (state == S_SCAN) begin
      if (key_hit) begin
        found <= 1'b1;
        slot  <= scan_idx;
        tail  <= obj_rd_tail;
      end else if (!scan_last) begin
        scan_idx <= scan_idx + OW'(1);
      end
    end
  end

  a_vcount_bound: assert property (@(posedge clk) disable iff (rst)
    vcount <= VCW'(VERSIONS))
    else $error("version count beyond table depth");

  a_obj_bound: assert property (@(posedge clk) disable iff (rst)
    obj_count <= CNTW'(OBJECTS))
    else $error("object count beyond table depth");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> CNTW'(scan_idx) < obj_count)
    else $error("scan index past the filled objects");

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    ver_wr_en |=> vcount == $past(vcount) + VCW'(1))
    else $error("version append did not advance the count");

  a_new_obj_room: assert property (@(posedge clk) disable iff (rst)
    go && do_new_obj |-> !obj_full && !found)
    else $error("object created without room or over a duplicate");

endmodule
